@@ src/rlps_pkg.sv @@
// ----------------------------------------------------------------------------
// rlps_pkg: shared types and constants for the RGB LED panel scan driver
// Panel geometry, scan timing, request kind codes and the stage control word.
// ----------------------------------------------------------------------------
package rlps_pkg;

	// Panel geometry
	localparam int PANEL_ROWS = 32;
	localparam int PANEL_COLS = 64;
	localparam int HALF_ROWS  = 16;
	localparam int ROW_W      = $clog2(PANEL_ROWS);
	localparam int COL_W      = $clog2(PANEL_COLS);
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int MEM_DEPTH  = PANEL_ROWS * PANEL_COLS;
	localparam int COLOR_W    = 3;
	localparam int RADDR_W    = 4;

	// Row timing: two ticks per column, then three end-of-row ticks
	localparam int SHIFT_TICKS = 2 * PANEL_COLS;
	localparam int ROW_TICKS   = SHIFT_TICKS + 3;
	localparam int TICK_W      = $clog2(ROW_TICKS);

	// Request kind carried on the input tuser line
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_SCAN  = 1'b1
	} req_kind_t;

	// Control word carried from the memory access stage to the pin stage
	typedef struct packed {
		logic               color_tick;
		logic               upper_half;
		logic               clock;
		logic               latch;
		logic               blank;
		logic [RADDR_W-1:0] addr;
		logic               row_done;
		logic               frame_done;
	} scan_ctl_t;

endpackage

@@ src/rgb_led_panel_scan_driver.sv @@
// ----------------------------------------------------------------------------
// rgb_led_panel_scan_driver: refresh controller for a 32x64 RGB LED panel
// Frame store of 3-bit pixels and a row scan sequencer driving the pin levels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per accepted beat. tuser selects the kind: a pixel
//   write (row, column, color in tdata) or a scan tick. Every request gives
//   exactly one beat on m_axis carrying the panel pin levels after it.
//   m_axis: tdata holds the color lines, clock, latch, blank and row address;
//   tlast marks the last tick of a row, tuser the last tick of the frame.
//   An accepted request passes the frame store read stage and then the output
//   register on its way to its result beat. A request can be accepted on every
//   clock while the receiver keeps up, so the sustained rate is one per cycle;
//   the frame store has one write port and one read port, and each request
//   uses at most one of them.
//   After reset the frame store is cleared one entry per cycle; s_axis_tready
//   stays low until the whole store is cleared. Pins reset to blanked.
//   When the receiver stalls, the output register holds its beat, the read
//   stage holds behind it and s_axis_tready drops while that stage is full.
// ----------------------------------------------------------------------------
module rgb_led_panel_scan_driver
	import rlps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [4:0] pixel_row, [10:5] pixel_col,
	                                    // [13:11] pixel_color, [15:14] zero
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [2:0] upper_color, [5:3] lower_color,
	                                    // [6] shift_clock, [7] latch_level,
	                                    // [8] blank_level, [12:9] row_address,
	                                    // [15:13] zero
	output logic        m_axis_tlast,  // row_done
	output logic        m_axis_tuser   // [0] frame_done
);

	// Input fields
	logic [ROW_W-1:0]   pixel_row;
	logic [COL_W-1:0]   pixel_col;
	logic [COLOR_W-1:0] pixel_color;
	req_kind_t          req_type;

	assign pixel_row   = s_axis_tdata[ROW_W-1:0];
	assign pixel_col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
	assign pixel_color = s_axis_tdata[ROW_W+COL_W+COLOR_W-1:ROW_W+COL_W];
	assign req_type    = req_kind_t'(s_axis_tuser);

	// Frame store and its clearing pass
	logic [COLOR_W-1:0] frame_mem [0:MEM_DEPTH-1];
	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// Sequencer state and held pins
	logic [ROW_W-1:0]   scan_row_q;
	logic [TICK_W-1:0]  tick_q;
	logic               pin_clock_q;
	logic               pin_latch_q;
	logic               pin_blank_q;
	logic [RADDR_W-1:0] pin_addr_q;
	logic [COLOR_W-1:0] pin_upper_q;
	logic [COLOR_W-1:0] pin_lower_q;

	// Pipeline
	logic               s1_valid;
	scan_ctl_t          ctl_s1;
	logic [COLOR_W-1:0] rd_data_s1;
	logic               out_valid_q;
	logic [15:0]        out_data_q;
	logic               out_last_q;
	logic               out_user_q;

	logic               s1_adv;
	logic               accept;
	logic               is_scan;
	logic               wr_in_range;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_en;
	scan_ctl_t          ctl_next;
	logic [ROW_W-1:0]   scan_row_next;
	logic [TICK_W-1:0]  tick_next;
	logic [COLOR_W-1:0] upper_s1;
	logic [COLOR_W-1:0] lower_s1;

	// Handshake: s1 moves on when the output register is free or drains
	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !clr_busy_q && (!s1_valid || s1_adv);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_scan       = (req_type == REQ_SCAN);

	// Pixel write bounds
	assign wr_in_range = ({1'b0, pixel_row} < (ROW_W+1)'(PANEL_ROWS)) &&
	                     ({1'b0, pixel_col} < (COL_W+1)'(PANEL_COLS));

	// Scan sequencer: next tick, next row and pin levels after this tick
	always_comb begin
		ctl_next            = '0;
		ctl_next.clock      = pin_clock_q;
		ctl_next.latch      = pin_latch_q;
		ctl_next.blank      = pin_blank_q;
		ctl_next.addr       = pin_addr_q;
		ctl_next.upper_half = ({1'b0, scan_row_q} < (ROW_W+1)'(HALF_ROWS));
		scan_row_next       = scan_row_q;
		tick_next           = tick_q;
		rd_addr             = {scan_row_q, tick_q[COL_W:1]};
		rd_en               = 1'b0;
		if (accept && is_scan) begin
			if (tick_q < TICK_W'(SHIFT_TICKS)) begin
				if (!tick_q[0]) begin
					ctl_next.color_tick = 1'b1;
					ctl_next.clock      = 1'b0;
					rd_en               = 1'b1;
				end else begin
					ctl_next.clock = 1'b1;
				end
				tick_next = tick_q + 1'b1;
			end else if (tick_q == TICK_W'(SHIFT_TICKS)) begin
				ctl_next.clock = 1'b0;
				ctl_next.blank = 1'b1;
				ctl_next.latch = 1'b1;
				ctl_next.addr  = scan_row_q[RADDR_W-1:0];
				tick_next      = tick_q + 1'b1;
			end else if (tick_q == TICK_W'(SHIFT_TICKS + 1)) begin
				ctl_next.latch = 1'b0;
				tick_next      = tick_q + 1'b1;
			end else begin
				ctl_next.blank    = 1'b0;
				ctl_next.row_done = 1'b1;
				tick_next         = '0;
				if (scan_row_q == ROW_W'(PANEL_ROWS - 1)) begin
					ctl_next.frame_done = 1'b1;
					scan_row_next       = '0;
				end else begin
					scan_row_next = scan_row_q + 1'b1;
				end
			end
		end
	end

	// Frame store write port: clearing pass first, then pixel writes
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {pixel_row, pixel_col};
		mem_wdata = pixel_color;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (accept && !is_scan && wr_in_range) begin
			mem_we = 1'b1;
		end
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= frame_mem[rd_addr];
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Sequencer state and non-color pins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= '0;
			tick_q      <= '0;
			pin_clock_q <= 1'b0;
			pin_latch_q <= 1'b0;
			pin_blank_q <= 1'b1;
			pin_addr_q  <= '0;
		end else if (accept) begin
			scan_row_q  <= scan_row_next;
			tick_q      <= tick_next;
			pin_clock_q <= ctl_next.clock;
			pin_latch_q <= ctl_next.latch;
			pin_blank_q <= ctl_next.blank;
			pin_addr_q  <= ctl_next.addr;
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_next;
		end
	end

	// Color lines from the read data, or held from earlier ticks
	always_comb begin
		upper_s1 = pin_upper_q;
		lower_s1 = pin_lower_q;
		if (ctl_s1.color_tick) begin
			upper_s1 = ctl_s1.upper_half ? rd_data_s1 : '0;
			lower_s1 = ctl_s1.upper_half ? '0 : rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_upper_q <= '0;
			pin_lower_q <= '0;
		end else if (s1_valid && s1_adv) begin
			pin_upper_q <= upper_s1;
			pin_lower_q <= lower_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_adv) begin
			out_data_q <= {3'b000, ctl_s1.addr, ctl_s1.blank, ctl_s1.latch,
			               ctl_s1.clock, lower_s1, upper_s1};
			out_last_q <= ctl_s1.row_done;
			out_user_q <= ctl_s1.frame_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

	// Checks
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_axis_tready)
		else $error("request taken during frame store clear");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TICK_W'(ROW_TICKS))
		else $error("row tick counter out of range");

	a_frame_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && ctl_s1.frame_done) |-> ctl_s1.row_done)
		else $error("frame end without row end");

	a_color_tick_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && ctl_s1.color_tick) |-> !ctl_s1.clock)
		else $error("color change with shift clock high");

	a_row_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl_next.row_done) |=> (tick_q == '0))
		else $error("row end did not restart tick counter");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RGB LED panel scan driver
// Sends pixel writes and scan ticks on the input stream and keeps a shadow
// frame store and pin sequencer in the bench. Every result beat on the
// output stream is compared field by field with the shadow pins. Both sides
// idle at random, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module testbench;
	import rlps_pkg::*;

	// One pending request as sent on s_axis
	typedef struct {
		req_kind_t          kind;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [COLOR_W-1:0] color;
	} panel_req_t;

	// Pin levels carried by one result beat
	typedef struct {
		logic [COLOR_W-1:0] upper;
		logic [COLOR_W-1:0] lower;
		logic               clock;
		logic               latch;
		logic               blank;
		logic [RADDR_W-1:0] addr;
		logic               row_done;
		logic               frame_done;
	} pin_levels_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [4:0] row, [10:5] col, [13:11] color, [15:14] zero
	logic        s_axis_tuser = 1'b0; // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // [2:0] upper, [5:3] lower, [6] clock, [7] latch,
	                             // [8] blank, [12:9] row address, [15:13] zero
	logic        m_axis_tlast;   // row_done
	logic        m_axis_tuser;   // [0] frame_done

	rgb_led_panel_scan_driver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock, 10 ns period
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow panel state
	logic [COLOR_W-1:0] shadow_store [MEM_DEPTH];
	logic [ROW_W-1:0]   shadow_row;
	int                 shadow_tick;
	pin_levels_t        shadow_pins;

	panel_req_t  pending_reqs [$];
	pin_levels_t pin_expect [$];
	panel_req_t  cur_req;
	int          errors = 0;
	int          results_seen = 0;

	// Sender and receiver idle pacing
	int send_gap = 0;
	int send_phase = 0;
	bit send_calm = 1'b0;
	int recv_stall = 0;
	int recv_phase = 0;
	bit recv_calm = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	task automatic report(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
		errors++;
	endtask

	// Idle length: mostly short, a few long, none in calm phases
	function automatic int idle_len(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// Advance the shadow panel by one request and queue the resulting pins
	task automatic apply_request(panel_req_t req);
		logic [COLOR_W-1:0] c;
		logic [COL_W-1:0]   col;
		pin_levels_t        p;
		p = shadow_pins;
		p.row_done = 1'b0;
		p.frame_done = 1'b0;
		if (req.kind == REQ_WRITE) begin
			shadow_store[{req.row, req.col}] = req.color;
		end else if (shadow_tick < SHIFT_TICKS) begin
			// Shift ticks: data with clock low, then clock high
			if (shadow_tick % 2 == 0) begin
				col = COL_W'(shadow_tick / 2);
				c = shadow_store[{shadow_row, col}];
				if (shadow_row < HALF_ROWS) begin
					p.upper = c;
					p.lower = '0;
				end else begin
					p.upper = '0;
					p.lower = c;
				end
				p.clock = 1'b0;
			end else begin
				p.clock = 1'b1;
			end
			shadow_tick++;
		end else if (shadow_tick == SHIFT_TICKS) begin
			// Blank and latch, present the row address
			p.clock = 1'b0;
			p.blank = 1'b1;
			p.latch = 1'b1;
			p.addr = shadow_row[RADDR_W-1:0];
			shadow_tick++;
		end else if (shadow_tick == SHIFT_TICKS + 1) begin
			p.latch = 1'b0;
			shadow_tick++;
		end else begin
			// Unblank and move to the next row
			p.blank = 1'b0;
			p.row_done = 1'b1;
			if (shadow_row == PANEL_ROWS - 1) begin
				p.frame_done = 1'b1;
				shadow_row = '0;
			end else begin
				shadow_row = shadow_row + 1'b1;
			end
			shadow_tick = 0;
		end
		shadow_pins = p;
		pin_expect.push_back(p);
	endtask

	// Request driver
	always @(posedge clk) begin : drive_requests
		logic       load;
		panel_req_t nxt;
		load = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(cur_req);
				load = 1'b1;
				if (send_phase == 0) begin
					send_calm = ($urandom_range(0, 3) == 0);
					send_phase = $urandom_range(20, 120);
				end else begin
					send_phase--;
				end
				send_gap = idle_len(send_calm);
			end else if (!s_axis_tvalid) begin
				load = 1'b1;
			end
			if (load) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					cur_req = nxt;
					s_axis_tdata <= {2'b00, nxt.color, nxt.col, nxt.row};
					s_axis_tuser <= nxt.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off so the input side backs up
	always @(posedge clk) begin : receiver_hold
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= 600) begin
				hold_left <= 150;
				hold_done <= 1'b1;
			end
		end
	end

	// Result monitor and receiver pacing
	always @(posedge clk) begin : watch_results
		pin_levels_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pin_expect.size() == 0) begin
					report("unexpected result", int'(m_axis_tdata), 0);
				end else begin
					want = pin_expect.pop_front();
					if (m_axis_tdata[2:0] !== want.upper)
						report("upper_color", int'(m_axis_tdata[2:0]), int'(want.upper));
					if (m_axis_tdata[5:3] !== want.lower)
						report("lower_color", int'(m_axis_tdata[5:3]), int'(want.lower));
					if (m_axis_tdata[6] !== want.clock)
						report("shift_clock", int'(m_axis_tdata[6]), int'(want.clock));
					if (m_axis_tdata[7] !== want.latch)
						report("latch_level", int'(m_axis_tdata[7]), int'(want.latch));
					if (m_axis_tdata[8] !== want.blank)
						report("blank_level", int'(m_axis_tdata[8]), int'(want.blank));
					if (m_axis_tdata[12:9] !== want.addr)
						report("row_address", int'(m_axis_tdata[12:9]), int'(want.addr));
					if (m_axis_tlast !== want.row_done)
						report("row_done", int'(m_axis_tlast), int'(want.row_done));
					if (m_axis_tuser !== want.frame_done)
						report("frame_done", int'(m_axis_tuser), int'(want.frame_done));
				end
				results_seen++;
				if (recv_phase == 0) begin
					recv_calm = ($urandom_range(0, 3) == 0);
					recv_phase = $urandom_range(20, 120);
				end else begin
					recv_phase--;
				end
				recv_stall = idle_len(recv_calm);
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : run_test
		panel_req_t req;
		int         n_items;
		for (int i = 0; i < MEM_DEPTH; i++)
			shadow_store[i] = '0;
		shadow_row = '0;
		shadow_tick = 0;
		shadow_pins = '{upper: '0, lower: '0, clock: 1'b0, latch: 1'b0, blank: 1'b1,
		                addr: '0, row_done: 1'b0, frame_done: 1'b0};

		// Directed: corner pixels, both halves, then the first columns of row 0
		req.kind = REQ_WRITE;
		req.row = 5'd0;  req.col = 6'd0;  req.color = 3'h7; pending_reqs.push_back(req);
		req.row = 5'd0;  req.col = 6'd1;  req.color = 3'h2; pending_reqs.push_back(req);
		req.row = 5'd0;  req.col = 6'd63; req.color = 3'h5; pending_reqs.push_back(req);
		req.row = 5'd31; req.col = 6'd63; req.color = 3'h7; pending_reqs.push_back(req);
		req.row = 5'd31; req.col = 6'd0;  req.color = 3'h1; pending_reqs.push_back(req);
		req.row = 5'd16; req.col = 6'd0;  req.color = 3'h6; pending_reqs.push_back(req);
		req.row = 5'd15; req.col = 6'd63; req.color = 3'h3; pending_reqs.push_back(req);
		req.row = 5'd0;  req.col = 6'd2;  req.color = 3'h0; pending_reqs.push_back(req);
		req.kind = REQ_SCAN;
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back(req);
		// Write ahead of and behind the scan position in the live row
		req.kind = REQ_WRITE;
		req.row = 5'd0; req.col = 6'd4; req.color = 3'h4; pending_reqs.push_back(req);
		req.row = 5'd0; req.col = 6'd3; req.color = 3'h1; pending_reqs.push_back(req);
		req.kind = REQ_SCAN;
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(req);

		// Random: mostly scan ticks
		n_items = 0;
		while (n_items < 1180) begin
			req.row = ROW_W'($urandom_range(0, PANEL_ROWS - 1));
			req.col = COL_W'($urandom_range(0, PANEL_COLS - 1));
			req.color = COLOR_W'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 85)
				req.kind = REQ_SCAN;
			else
				req.kind = REQ_WRITE;
			pending_reqs.push_back(req);
			n_items++;
		end

		// Hold reset, then release it
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || pin_expect.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[rgb_led_panel_scan_driver] OK");
		else
			$display("[rgb_led_panel_scan_driver] ERROR");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#40_000_000;
		$display("[rgb_led_panel_scan_driver] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
src/rlps_pkg.sv
src/rgb_led_panel_scan_driver.sv
tb/testbench.sv
